// File: sv/tfd_pkg.sv
// Package for the thermometer frame decoder: frame constants, phase and
// sequencer state types. No dependencies.
`timescale 1ns / 1ps
package tfd_pkg;
	localparam int MaxPayload  = 32;
	localparam int RecordBytes = 20;
	localparam int PidxW = $clog2(MaxPayload);
	localparam int RidxW = $clog2(RecordBytes);

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] TYPE_LIVE = 8'h00;
	localparam logic [7:0] TYPE_META = 8'h11;
	localparam logic [7:0] TYPE_LOG  = 8'h14;
	localparam logic [7:0] TYPE_END  = 8'h19;

	localparam logic [1:0] KIND_LIVE = 2'd0;
	localparam logic [1:0] KIND_REC  = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic REG_DATA_SOURCE  = 1'b0;
	localparam logic REG_PROBE_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		PH_SYNC1, PH_SYNC2, PH_TYPE, PH_LEN, PH_PAYLOAD, PH_CHECK, PH_SKIP
	} phase_t;

	// Sequencer: IDLE takes bytes; only LOG walks the stored payload.
	typedef enum logic [2:0] {
		SQ_IDLE, SQ_LIVE, SQ_LIVE2, SQ_LOG, SQ_REC, SQ_OUT
	} seq_t;
endpackage

// File: sv/thermometer_frame_decoder_unit.sv
// Top level of the thermometer frame decoder: frame parser, payload store,
// record assembler and result register. Depends on tfd_pkg.
`timescale 1ns / 1ps
// A good live frame converts probe A in SQ_LIVE and probe B in SQ_LIVE2, then
// shows its result. A good log frame walks one payload byte per cycle (up to 32)
// while no result waits; each full record goes through SQ_REC and SQ_OUT.
// Throughput: one byte per cycle, except while the sequencer is busy and while a
// result waits. The shared unit is one temperature converter (x10 adder).
// Reset clears all control state and the payload store valid bits.
module thermometer_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic        last,
	output logic [3:0]  mode_flags,
	output logic signed [19:0] temp_a_tenths,
	output logic        over_a,
	output logic signed [19:0] temp_b_tenths,
	output logic        over_b,
	output logic [1:0]  probes_present
);
	import tfd_pkg::*;

	logic        src_q;
	logic [1:0]  pen_q;
	phase_t      ph_q;
	seq_t        sq_q, sq_d;
	logic [7:0]  type_q, len_q, sum_q;
	logic [7:0]  cnt_q;
	logic [7:0]  pay_q [MaxPayload];
	logic [MaxPayload-1:0] pv_q;
	logic [7:0]  rec_q [RecordBytes];
	logic [4:0]  fill_q;
	logic [15:0] left_q;
	logic [PidxW:0] wi_q;
	logic [1:0]  nres_q;
	logic        pr_q;

	// Result register.
	logic        ov_q;
	logic [1:0]  kind_q, pp_q;
	logic        last_q, oa_q, ob_q;
	logic [3:0]  mf_q;
	logic signed [19:0] ta_q, tb_q;

	logic acc_in, acc_out;
	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;
	assign in_ready  = (sq_q == SQ_IDLE) && !ov_q;
	assign cfg_ready = 1'b1;

	function automatic logic [7:0] pat(input logic [PidxW:0] i, input logic [7:0] len,
			input logic [MaxPayload-1:0] v, input logic [7:0] d);
		pat = ({3'd0, i} < len && v[i[PidxW-1:0]]) ? d : 8'd0;
	endfunction

	// Shared converter: probe pr_q from the payload (live) or record (log).
	logic [PidxW:0] b0;
	logic [7:0]  lo, hi, fl;
	logic signed [15:0] raw;
	logic signed [19:0] conv_t;
	logic        conv_o;
	always_comb begin
		b0 = (PidxW+1)'(14 + 3 * pr_q);
		lo = pat(b0, len_q, pv_q, pay_q[b0[PidxW-1:0]]);
		hi = pat(b0 + 1'b1, len_q, pv_q, pay_q[b0[PidxW-1:0] + 1'b1]);
		fl = pat(b0 + 2'd2, len_q, pv_q, pay_q[b0[PidxW-1:0] + 2'd2]);
		conv_t = '0;
		conv_o = 1'b0;
		if (sq_q == SQ_REC) begin
			lo = rec_q[RidxW'(12 + 2 * pr_q)];
			hi = rec_q[RidxW'(13 + 2 * pr_q)];
			raw = {hi, lo};
			if ({hi, lo} == 16'h7FFF) conv_o = 1'b1;
			else conv_t = 20'(raw);
		end else begin
			raw = {hi, lo};
			if ((fl & 8'h60) != 8'd0) conv_o = 1'b1;
			else if (fl[0]) conv_t = 20'(raw);
			else conv_t = (20'(raw) <<< 3) + (20'(raw) <<< 1);
		end
		if (!pen_q[pr_q]) begin
			conv_t = '0;
			conv_o = 1'b0;
		end
	end

	logic [7:0] disp;
	logic [3:0] flg;
	assign disp = pat((PidxW+1)'(13), len_q, pv_q, pay_q[PidxW'(13)]);
	assign flg = {disp[3:2] == 2'b11, disp[3:2] == 2'b10, disp[3:2] == 2'b01,
		disp[7:4] == 4'h2};

	logic good_chk;
	assign good_chk = acc_in && ph_q == PH_CHECK && rx_byte == sum_q;

	logic wdone;
	assign wdone = wi_q >= (PidxW+1)'(MaxPayload) || {3'd0, wi_q} >= len_q ||
		left_q == 16'd0 || nres_q == 2'd2;

	always_comb begin
		sq_d = sq_q;
		case (sq_q)
			SQ_IDLE: if (good_chk) begin
				if (type_q == TYPE_LIVE && !src_q) sq_d = SQ_LIVE;
				else if (type_q == TYPE_LOG && src_q) sq_d = SQ_LOG;
			end
			SQ_LIVE:  sq_d = SQ_LIVE2;
			SQ_LIVE2: sq_d = SQ_OUT;
			SQ_LOG: begin
				if (ov_q) sq_d = SQ_LOG;
				else if (wdone) sq_d = SQ_IDLE;
				else if (fill_q == 5'(RecordBytes - 1)) sq_d = SQ_REC;
			end
			SQ_REC: if (pr_q) sq_d = SQ_OUT;
			SQ_OUT: sq_d = (type_q == TYPE_LOG) ? SQ_LOG : SQ_IDLE;
			default: sq_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 1'b0;
			pen_q <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DATA_SOURCE) src_q <= cfg_data[0];
			else pen_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SYNC1;
			sq_q <= SQ_IDLE;
			type_q <= '0; len_q <= '0; sum_q <= '0; cnt_q <= '0;
			pv_q <= '0; fill_q <= '0; left_q <= '0;
			wi_q <= '0; nres_q <= '0; pr_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			sq_q <= sq_d;
			if (acc_out) ov_q <= 1'b0;
			if (acc_in) begin
				case (ph_q)
					PH_SYNC1: if (rx_byte == SYNC_BYTE) begin
						sum_q <= rx_byte; ph_q <= PH_SYNC2;
					end
					PH_SYNC2: if (rx_byte == SYNC_BYTE) begin
						sum_q <= sum_q + rx_byte; ph_q <= PH_TYPE;
					end else ph_q <= PH_SYNC1;
					PH_TYPE: begin
						type_q <= rx_byte; sum_q <= sum_q + rx_byte; ph_q <= PH_LEN;
					end
					PH_LEN: begin
						len_q <= rx_byte; sum_q <= sum_q + rx_byte; cnt_q <= '0;
						if (rx_byte > 8'(MaxPayload)) ph_q <= PH_SKIP;
						else if (rx_byte == 8'd0) ph_q <= PH_CHECK;
						else ph_q <= PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						pv_q[cnt_q[PidxW-1:0]] <= 1'b1;
						cnt_q <= cnt_q + 1'b1; sum_q <= sum_q + rx_byte;
						if (cnt_q + 1'b1 >= len_q) ph_q <= PH_CHECK;
					end
					PH_CHECK: begin
						ph_q <= PH_SYNC1;
						if (rx_byte == sum_q && type_q == TYPE_META)
							left_q <= {pat((PidxW+1)'(5), len_q, pv_q, pay_q[PidxW'(5)]),
								pat((PidxW+1)'(4), len_q, pv_q, pay_q[PidxW'(4)])};
						if (rx_byte == sum_q && type_q == TYPE_END && src_q)
							ov_q <= 1'b1;
						wi_q <= '0; nres_q <= '0; pr_q <= 1'b0;
					end
					PH_SKIP: begin
						// The count runs one past a length of 255, so compare at 9 bits.
						cnt_q <= cnt_q + 1'b1;
						if ({1'b0, cnt_q} + 9'd1 > {1'b0, len_q}) ph_q <= PH_SYNC1;
					end
					default: ph_q <= PH_SYNC1;
				endcase
			end
			case (sq_q)
				SQ_LIVE:  pr_q <= 1'b1;
				SQ_LIVE2: begin pr_q <= 1'b0; ov_q <= 1'b1; end
				SQ_LOG: if (!ov_q && !wdone) begin
					wi_q <= wi_q + 1'b1;
					if (fill_q == 5'(RecordBytes - 1)) begin
						fill_q <= '0; left_q <= left_q - 1'b1; nres_q <= nres_q + 1'b1;
					end else fill_q <= fill_q + 1'b1;
				end
				SQ_REC: begin
					pr_q <= ~pr_q;
					if (pr_q) ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload and record memories.
	always_ff @(posedge clk) begin
		if (acc_in && ph_q == PH_PAYLOAD && cnt_q < 8'(MaxPayload))
			pay_q[cnt_q[PidxW-1:0]] <= rx_byte;
		if (sq_q == SQ_LOG && !ov_q && !wdone)
			rec_q[fill_q[RidxW-1:0]] <= pay_q[wi_q[PidxW-1:0]];
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (acc_in && ph_q == PH_CHECK) begin
			kind_q <= KIND_END; last_q <= 1'b1; mf_q <= '0;
			ta_q <= '0; tb_q <= '0; oa_q <= 1'b0; ob_q <= 1'b0; pp_q <= '0;
		end
		if (sq_q == SQ_LIVE || sq_q == SQ_LIVE2 || sq_q == SQ_REC) begin
			if (!pr_q) begin ta_q <= conv_t; oa_q <= conv_o; end
			else begin tb_q <= conv_t; ob_q <= conv_o; end
			pp_q <= pen_q;
			kind_q <= (sq_q == SQ_REC) ? KIND_REC : KIND_LIVE;
			mf_q <= (sq_q == SQ_REC) ? 4'd0 : flg;
		end
		if (sq_q == SQ_LIVE) last_q <= 1'b1;
		// A record is last unless another record can still complete.
		if (sq_q == SQ_REC && pr_q)
			last_q <= !(nres_q == 2'd1 && left_q != 16'd0 &&
				9'(len_q) >= 9'(wi_q) + 9'(RecordBytes) && wi_q + (PidxW+1)'(RecordBytes) <=
				(PidxW+1)'(MaxPayload));
	end

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign last = last_q;
	assign mode_flags = mf_q;
	assign temp_a_tenths = ta_q;
	assign over_a = oa_q;
	assign temp_b_tenths = tb_q;
	assign over_b = ob_q;
	assign probes_present = pp_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q != SQ_IDLE |-> !in_ready) else $error("input taken while busy");
	a_two_max: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q != 2'd3) else $error("more than two results");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result lost");
endmodule

// File: tb/tb_thermometer_frame_decoder_unit.sv
// Self-checking testbench for thermometer_frame_decoder_unit: serial frames in,
// decoded readings and log records out, checked against an in-bench predictor.
// Depends on tfd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module tb_thermometer_frame_decoder_unit;
	import tfd_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic        last;
		logic [3:0]  mode_flags;
		logic [19:0] temp_a;
		logic        over_a;
		logic [19:0] temp_b;
		logic        over_b;
		logic [1:0]  present;
	} reading_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [7:0] rx_byte;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [1:0] cfg_data;
	logic out_valid, out_ready;
	logic [1:0] kind;
	logic last;
	logic [3:0] mode_flags;
	logic signed [19:0] temp_a_tenths, temp_b_tenths;
	logic over_a, over_b;
	logic [1:0] probes_present;

	thermometer_frame_decoder_unit dut (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Predictor state.
	logic       src_log;
	logic [1:0] probe_mask;
	phase_t     ph;
	logic [7:0] ftype, flen, fsum;
	int         bcount;
	logic [7:0] payload [MaxPayload];
	logic [7:0] rec_buf [RecordBytes];
	int         rec_fill;
	logic [15:0] recs_left;

	logic [7:0] byte_q [$];
	reading_t   expected_q [$];
	int         errors, mismatches, held, stall;
	longint     cycles;
	bit         stim_done, hold_tx;

	function automatic logic [7:0] pay_at(int idx);
		if (idx >= flen || idx >= MaxPayload) return 8'h00;
		return payload[idx];
	endfunction

	function automatic reading_t live_reading();
		reading_t r;
		logic [7:0] d, fl;
		int raw, t;
		r = '0;
		r.kind = KIND_LIVE;
		r.present = probe_mask;
		d = pay_at(13);
		if ((d & 8'hF0) == 8'h20) r.mode_flags[0] = 1'b1;
		if ((d & 8'h0C) == 8'h04) r.mode_flags[1] = 1'b1;
		if ((d & 8'h0C) == 8'h08) r.mode_flags[2] = 1'b1;
		if ((d & 8'h0C) == 8'h0C) r.mode_flags[3] = 1'b1;
		for (int p = 0; p < 2; p++) begin
			raw = $signed({pay_at(15 + 3 * p), pay_at(14 + 3 * p)});
			fl = pay_at(16 + 3 * p);
			t = 0;
			if (probe_mask[p]) begin
				if (fl & 8'h60) begin
					if (p == 0) r.over_a = 1'b1; else r.over_b = 1'b1;
				end else if (fl[0]) t = raw;
				else t = raw * 10;
			end
			if (p == 0) r.temp_a = t[19:0]; else r.temp_b = t[19:0];
		end
		return r;
	endfunction

	function automatic reading_t log_reading();
		reading_t r;
		logic [15:0] v;
		int t;
		r = '0;
		r.kind = KIND_REC;
		r.present = probe_mask;
		for (int p = 0; p < 2; p++) begin
			v = {rec_buf[13 + 2 * p], rec_buf[12 + 2 * p]};
			t = 0;
			if (probe_mask[p]) begin
				if (v == 16'h7FFF) begin
					if (p == 0) r.over_a = 1'b1; else r.over_b = 1'b1;
				end else t = $signed(v);
			end
			if (p == 0) r.temp_a = t[19:0]; else r.temp_b = t[19:0];
		end
		return r;
	endfunction

	// Runs the frame parser over one byte and queues what it should produce.
	task automatic decode_byte(input logic [7:0] b);
		reading_t res [$];
		reading_t r;
		case (ph)
			PH_SYNC1: if (b == SYNC_BYTE) begin fsum = b; ph = PH_SYNC2; end
			PH_SYNC2: begin
				if (b == SYNC_BYTE) begin fsum += b; ph = PH_TYPE; end
				else ph = PH_SYNC1;
			end
			PH_TYPE: begin ftype = b; fsum += b; ph = PH_LEN; end
			PH_LEN: begin
				flen = b; fsum += b; bcount = 0;
				if (b > MaxPayload) ph = PH_SKIP;
				else if (b == 0) ph = PH_CHECK;
				else ph = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (bcount < MaxPayload) payload[bcount] = b;
				bcount++; fsum += b;
				if (bcount >= flen) ph = PH_CHECK;
			end
			PH_CHECK: begin
				ph = PH_SYNC1;
				if (b == fsum) begin
					if (ftype == TYPE_LIVE) begin
						if (!src_log) res.push_back(live_reading());
					end else if (ftype == TYPE_META) begin
						recs_left = {pay_at(5), pay_at(4)};
					end else if (ftype == TYPE_LOG) begin
						if (src_log)
							for (int i = 0; i < flen && i < MaxPayload; i++) begin
								if (recs_left == 0 || res.size() >= 2) break;
								rec_buf[rec_fill] = payload[i];
								rec_fill++;
								if (rec_fill >= RecordBytes) begin
									res.push_back(log_reading());
									rec_fill = 0;
									recs_left--;
								end
							end
					end else if (ftype == TYPE_END) begin
						if (src_log) begin
							r = '0;
							r.kind = KIND_END;
							res.push_back(r);
						end
					end
				end
			end
			PH_SKIP: begin
				bcount++;
				if (bcount > flen) ph = PH_SYNC1;
			end
			default: ph = PH_SYNC1;
		endcase
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
		foreach (res[i]) expected_q.push_back(res[i]);
	endtask

	// Driver: the predictor runs when the transaction is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			held = 0;
		end else begin
			if (in_valid && in_ready) decode_byte(rx_byte);
			if (in_valid && !in_ready) begin
			end else if (held > 0) begin
				held--;
				in_valid <= 1'b0;
			end else if (hold_tx || byte_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				if ($urandom_range(0, 3) == 0)
					held = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
						: $urandom_range(1, 3);
				if (held > 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte <= byte_q.pop_front();
				end
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		reading_t got, want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{kind, last, mode_flags, temp_a_tenths, over_a,
					temp_b_tenths, over_b, probes_present};
				if (expected_q.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (mismatches++ < 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
					: $urandom_range(1, 3);
				out_ready <= 1'b0;
			end else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add_frame(input logic [7:0] t, input logic [7:0] pl [$],
			input bit corrupt);
		logic [7:0] s;
		s = SYNC_BYTE + SYNC_BYTE + t + 8'(pl.size());
		byte_q.push_back(SYNC_BYTE);
		byte_q.push_back(SYNC_BYTE);
		byte_q.push_back(t);
		byte_q.push_back(8'(pl.size()));
		foreach (pl[i]) begin byte_q.push_back(pl[i]); s += pl[i]; end
		byte_q.push_back(corrupt ? s ^ 8'(1 << $urandom_range(0, 7)) : s);
	endtask

	function automatic logic [7:0] rnd_flag();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h20 << $urandom_range(0, 1);
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_live(input int len);
		logic [7:0] pl [$];
		for (int i = 0; i < len; i++) pl.push_back(8'($urandom));
		if (len > 16) pl[16] = rnd_flag();
		if (len > 19) pl[19] = rnd_flag();
		if (len > 13 && $urandom_range(0, 1)) pl[13] = {4'h2, 4'($urandom)};
		add_frame(TYPE_LIVE, pl, $urandom_range(0, 15) == 0);
	endtask

	task automatic add_meta(input int recs);
		logic [7:0] pl [$];
		for (int i = 0; i < 6; i++) pl.push_back(8'($urandom));
		pl[4] = recs[7:0];
		pl[5] = recs[15:8];
		add_frame(TYPE_META, pl, 1'b0);
	endtask

	task automatic add_log(input int len);
		logic [7:0] pl [$];
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			pl.push_back(r == 0 ? 8'hFF : r == 1 ? 8'h7F : 8'($urandom));
		end
		add_frame(TYPE_LOG, pl, $urandom_range(0, 15) == 0);
	endtask

	task automatic add_noise(input int n);
		for (int i = 0; i < n; i++) byte_q.push_back(8'($urandom));
	endtask

	task automatic wait_drained();
		while (byte_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DATA_SOURCE) src_log = val[0]; else probe_mask = val;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] pl [$];
		errors = 0; mismatches = 0; cycles = 0; hold_tx = 0;
		src_log = 1'b0; probe_mask = 2'd3; ph = PH_SYNC1;
		ftype = 0; flen = 0; fsum = 0; bcount = 0; rec_fill = 0; recs_left = 0;
		foreach (payload[i]) payload[i] = 8'h00;
		cfg_valid = 1'b0; cfg_index = REG_DATA_SOURCE; cfg_data = 2'd0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed live part: short frame, zero length, bad syncs, oversized,
		// unknown type, log frames in live mode.
		add_live(20);
		pl = {}; pl.push_back(8'h00); pl.push_back(8'hFF);
		add_frame(TYPE_LIVE, pl, 1'b0);
		pl = {}; add_frame(TYPE_LIVE, pl, 1'b0);
		byte_q.push_back(8'hAA); byte_q.push_back(SYNC_BYTE); byte_q.push_back(8'h54);
		byte_q.push_back(SYNC_BYTE); byte_q.push_back(SYNC_BYTE);
		byte_q.push_back(TYPE_LIVE); byte_q.push_back(8'hFF);
		add_noise(257);
		add_live(32);
		add_frame(8'h18, pl, 1'b0);
		add_log(20);
		add_frame(TYPE_END, pl, 1'b0);
		add_live(19);
		wait_drained();

		hold_tx = 1;
		write_reg(REG_DATA_SOURCE, 2'd1);
		write_reg(REG_PROBE_ENABLE, 2'd0);
		hold_tx = 0;
		add_log(20);
		add_meta(2);
		add_log(32); add_log(32); add_log(5);
		add_frame(TYPE_END, pl, 1'b0);
		add_meta(3);
		add_live(20);
		add_log(0);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			hold_tx = 1;
			write_reg(REG_DATA_SOURCE, 2'(phase % 2));
			write_reg(REG_PROBE_ENABLE, 2'($urandom_range(0, 3)));
			hold_tx = 0;
			while (byte_q.size() < 170) begin
				case ($urandom_range(0, 9))
					0: add_noise($urandom_range(1, 6));
					1: add_meta($urandom_range(0, 12));
					2: add_frame(TYPE_END, pl, $urandom_range(0, 7) == 0);
					3: add_live($urandom_range(0, 32));
					4: begin
						byte_q.push_back(SYNC_BYTE); byte_q.push_back(SYNC_BYTE);
						byte_q.push_back(8'($urandom));
						byte_q.push_back(8'($urandom_range(33, 60)));
						add_noise($urandom_range(0, 70));
					end
					default: begin
						if (phase % 2) add_log($urandom_range(0, 32));
						else add_live($urandom_range(17, 32));
					end
				endcase
			end
			wait_drained();
		end

		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
